### src/nald_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Annex B NAL deframer.
// Used by every module of the block; depends on nothing else.
package nald_pkg;

    // Largest unit length the length field reports before it saturates.
    localparam int MAX_UNIT_BYTES = 1048576;

    localparam int LEN_W        = 21;
    localparam int LEN_ALL_ONES = (1 << LEN_W) - 1;
    localparam int LEN_LIMIT    = (MAX_UNIT_BYTES < LEN_ALL_ONES) ? MAX_UNIT_BYTES
                                                                  : LEN_ALL_ONES;
    localparam logic [LEN_W-1:0] LEN_LIMIT_V = LEN_W'(LEN_LIMIT);

    localparam int ZCNT_W = 2;
    localparam logic [ZCNT_W-1:0] ZERO_HOLD_MAX = 2'd3;
    localparam logic [ZCNT_W-1:0] ZERO_START_MIN = 2'd2;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_EPB  = 8'h03;

    // Command queue between the classifier and the result generator.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_unit_end;
        logic [LEN_W-1:0] unit_length;
        logic             stream_done;
        logic             last_of_run;
    } out_item_t;

    // One classified input byte. The back end expands it into results in the
    // order: leading 03, held zeros, trailing 03, payload byte, marker.
    typedef struct packed {
        logic              pre_three;
        logic [ZCNT_W-1:0] zeros;
        logic              post_three;
        logic              has_byte;
        logic [7:0]        data;
        logic              has_mark;
        logic              is_end;
        logic [LEN_W-1:0]  length;
        logic              done;
    } cmd_t;

endpackage

### src/nald_front.sv
`timescale 1ns / 1ps
// Front end of the deframer: accepts stream bytes, tracks start-code and
// emulation-prevention state; at most one command per byte. Uses nald_pkg.
module nald_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nald_pkg::in_item_t item,
    input  logic              q_full,
    output logic              full,
    output logic              cmd_wr,
    output nald_pkg::cmd_t    cmd
);
    import nald_pkg::*;

    logic              inside_reg, inside_next;
    logic [ZCNT_W-1:0] held_reg, held_next;
    logic              pending_reg, pending_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    logic              accept;
    logic [7:0]        b;
    logic [2:0]        add_k;
    cmd_t              c;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] base,
                                                 input logic [2:0] k);
        logic [LEN_W:0] s;
        begin
            s = {1'b0, base} + {{(LEN_W - 2){1'b0}}, k};
            if (s >= {1'b0, LEN_LIMIT_V})
            begin
                sat_add = LEN_LIMIT_V;
            end
            else
            begin
                sat_add = s[LEN_W-1:0];
            end
        end
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;
    assign b      = item.in_byte;

    always_comb
    begin
        inside_next  = inside_reg;
        held_next    = held_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        c            = '0;
        add_k        = '0;
        if (item.end_of_stream)
        begin
            c.has_mark = 1'b1;
            c.done     = 1'b1;
            if (inside_reg)
            begin
                c.zeros      = held_reg;
                c.post_three = pending_reg;
                c.is_end     = 1'b1;
                add_k        = {1'b0, held_reg} + {2'b0, pending_reg};
                c.length     = sat_add(count_reg, add_k);
            end
            inside_next  = 1'b0;
            held_next    = '0;
            pending_next = 1'b0;
            count_next   = '0;
        end
        else if (!inside_reg)
        begin
            if (b == BYTE_ZERO)
            begin
                if (held_reg != ZERO_HOLD_MAX)
                begin
                    held_next = held_reg + 2'd1;
                end
            end
            else if (b == BYTE_ONE && held_reg >= ZERO_START_MIN)
            begin
                inside_next = 1'b1;
                count_next  = '0;
                held_next   = '0;
            end
            else
            begin
                held_next = '0;
            end
        end
        else
        begin
            // A pending 03 is kept only when the byte after it is above 03.
            c.pre_three  = pending_reg && (b > BYTE_EPB);
            pending_next = 1'b0;
            if (b == BYTE_ZERO)
            begin
                if (held_reg == ZERO_HOLD_MAX)
                begin
                    c.zeros = 2'd1;
                end
                else
                begin
                    held_next = held_reg + 2'd1;
                end
            end
            else if (b == BYTE_ONE && held_reg >= ZERO_START_MIN)
            begin
                // The held zeros belong to the start code and are dropped.
                c.has_mark = 1'b1;
                c.is_end   = 1'b1;
                c.length   = count_reg;
                held_next  = '0;
            end
            else if (b == BYTE_EPB && held_reg >= ZERO_START_MIN)
            begin
                c.zeros      = held_reg;
                held_next    = '0;
                pending_next = 1'b1;
            end
            else
            begin
                c.zeros    = held_reg;
                c.has_byte = 1'b1;
                c.data     = b;
                held_next  = '0;
            end
            add_k = {2'b0, c.pre_three} + {1'b0, c.zeros} + {2'b0, c.has_byte};
            if (c.has_mark)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = sat_add(count_reg, add_k);
            end
        end
    end

    assign cmd    = c;
    assign cmd_wr = accept && (c.pre_three || (c.zeros != '0) || c.post_three
                               || c.has_byte || c.has_mark);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            held_reg    <= '0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            inside_reg  <= inside_next;
            held_reg    <= held_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

    // A pending 03 is only ever set after the held zeros were flushed.
    a_pending_no_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (held_reg == '0 && inside_reg))
        else $error("pending 03 with held zeros or outside a unit");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_LIMIT_V)
        else $error("payload count above the length limit");

endmodule

### src/nald_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the deframer front and back ends.
// Register-based, one write and one head read per cycle. Uses nald_pkg.
module nald_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  nald_pkg::cmd_t wr_data,
    input  logic           rd,
    output nald_pkg::cmd_t rd_data,
    output logic           full,
    output logic           not_empty
);
    import nald_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(wr && !rd))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> not_empty)
        else $error("command queue underflow");

endmodule

### src/nald_back.sv
`timescale 1ns / 1ps
// Back end of the deframer (uses nald_pkg): expands queued commands into
// result beats, one per cycle while popped, through an output register.
module nald_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  nald_pkg::cmd_t      q_head,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output nald_pkg::out_item_t result
);
    import nald_pkg::*;

    cmd_t      cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    cmd_t      rest;
    out_item_t beat;
    logic      advance;
    logic      rest_empty;

    // Pick the next beat of the current command and what remains after it.
    always_comb
    begin
        rest = cur_reg;
        beat = '0;
        if (cur_reg.pre_three)
        begin
            beat.out_byte  = BYTE_EPB;
            rest.pre_three = 1'b0;
        end
        else if (cur_reg.zeros != '0)
        begin
            beat.out_byte = BYTE_ZERO;
            rest.zeros    = cur_reg.zeros - 2'd1;
        end
        else if (cur_reg.post_three)
        begin
            beat.out_byte   = BYTE_EPB;
            rest.post_three = 1'b0;
        end
        else if (cur_reg.has_byte)
        begin
            beat.out_byte = cur_reg.data;
            rest.has_byte = 1'b0;
        end
        else
        begin
            beat.is_unit_end = cur_reg.is_end;
            beat.unit_length = cur_reg.length;
            beat.stream_done = cur_reg.done;
            rest.has_mark    = 1'b0;
        end
        rest_empty = !(rest.pre_three || (rest.zeros != '0) || rest.post_three
                       || rest.has_byte || rest.has_mark);
        beat.last_of_run = rest_empty;
    end

    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign q_rd    = q_not_empty && (!cur_valid_reg || (advance && rest_empty));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance)
        begin
            out_next       = beat;
            out_valid_next = 1'b1;
            cur_next       = rest;
            if (rest_empty)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_rd)
        begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // A held command always has at least one beat left to give.
    a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.pre_three || cur_reg.zeros != '0
                           || cur_reg.post_three || cur_reg.has_byte
                           || cur_reg.has_mark))
        else $error("current command has no beats left");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stream_done) |-> out_reg.last_of_run)
        else $error("stream-done beat is not the last of its run");

endmodule

### src/annexb_nal_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the H.264 Annex B NAL deframer. Instantiates the front end,
// the command queue and the back end; uses nald_pkg.
//
// The block takes one raw Annex B stream byte per beat on a queue-style input
// (push/full) and delivers RBSP payload bytes and end-of-unit markers on a
// queue-style output (empty/pop). Bytes before the first start code are
// dropped, start codes are stripped, and emulation-prevention 03 bytes are
// removed. An end_of_stream beat flushes held bytes and closes the stream.
// Each input byte is classified in the cycle it is accepted, so the input
// sustains one byte per cycle as long as the output is drained. The output
// side gives one result per cycle while popped; a single input can cause
// up to four results (three held zeros and the closing marker at the end of
// the stream), and such bursts are absorbed by a four-entry command queue,
// after which full rises until the back end catches up. Each command passes
// through the queue, a current-command register and the output register.
module annexb_nal_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nald_pkg::in_item_t  stream_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output nald_pkg::out_item_t result
);
    import nald_pkg::*;

    cmd_t fe_cmd;
    logic fe_wr;
    cmd_t q_head;
    logic q_full;
    logic q_not_empty;
    logic q_rd;

    nald_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (stream_item),
        .q_full (q_full),
        .full   (full),
        .cmd_wr (fe_wr),
        .cmd    (fe_cmd)
    );

    nald_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (fe_wr),
        .wr_data   (fe_cmd),
        .rd        (q_rd),
        .rd_data   (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    nald_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule
